>>> rtl/core/bfh_pkg.sv
// Shared types, constants and hash helpers for the three-hash Bloom filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package bfh_pkg;

  localparam int KEY_W         = 64;
  localparam int HASH_W        = 32;
  localparam int CELLS_W       = 17;
  localparam int HEN_W         = 3;
  localparam int NUM_HASH      = 3;
  localparam int NUM_CELLS_DEF = 65536;
  localparam int SFH_ROUNDS    = 16;
  localparam int SFH_STEPS     = SFH_ROUNDS + 6;
  localparam int SFH_STEP_W    = $clog2(SFH_STEPS);

  localparam logic [CELLS_W-1:0] CELLS_RST = CELLS_W'(65536);
  localparam logic [HEN_W-1:0]   HEN_RST   = HEN_W'(2);
  localparam logic [HASH_W-1:0]  SFH_INIT  = HASH_W'(64);
  localparam logic [HASH_W-1:0]  DJB_BASE  = HASH_W'(177573);

  // register select on paddr[2]
  localparam logic REG_CELLS = 1'b0;
  localparam logic REG_HEN   = 1'b1;

  localparam logic ACT_QUERY = 1'b1;

  // one hashed item handed from front to back
  typedef struct packed {
    logic              query;
    logic [HASH_W-1:0] h0;
    logic [HASH_W-1:0] h1;
    logic [HASH_W-1:0] h2;
  } bfh_job_t;

  function automatic logic [HASH_W-1:0] djb2_hash(input logic [KEY_W-1:0] k);
    return DJB_BASE + k[41:10] - {k[28:0], 3'b000};
  endfunction

  // one mixing round of the superfasthash variant
  function automatic logic [HASH_W-1:0] sfh_round(input logic [HASH_W-1:0] h,
                                                   input logic [15:0] lo);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] t;
    logic [HASH_W-1:0] b;
    a = h + {16'd0, lo};
    t = ({16'd0, lo} + HASH_W'(2)) << 11;
    t = t ^ a;
    b = (a << 16) ^ t;
    return b + (b >> 11);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/bloom_filter_three_hash_unit.sv
// Bloom filter over 64-bit keys with up to three hash probes (djb2, the low
// 32 key bits, superfasthash variant). The front takes an item on its accept
// beat, runs 22 steps of the 16-round hash, then pushes it to the queue once
// there is room. The back handles each enabled probe with select, a
// bit-serial modulo over the 32 hash bits, read, then check and set of the
// bit memory, and does only a select for each disabled probe. A waiting result
// holds the back, so it pops the next queue item only once that result is
// popped. The front hashes the next key while the back works on an item.
// After reset the bit memory is cleared one cell per cycle, and full stays
// high during that time.
// Depends on bfh_pkg, bfh_front, bfh_queue, bfh_back.
`default_nettype none
module bloom_filter_three_hash_unit
  import bfh_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire logic             in_action,
  input  wire logic [KEY_W-1:0] in_key,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output logic                  out_all_set,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int MW = $clog2(NUM_CELLS + 1);

  logic [CELLS_W-1:0] cells_r;
  logic [HEN_W-1:0]   hen_r;
  logic [31:0]        m_wide;
  logic [MW-1:0]      modulus;
  logic               front_busy;
  logic               clearing;
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  bfh_job_t           wr_job;
  bfh_job_t           rd_job;
  logic               res_valid;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= CELLS_RST;
      hen_r   <= HEN_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_CELLS: cells_r <= pwdata[CELLS_W-1:0];
        REG_HEN:   hen_r   <= pwdata[HEN_W-1:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_HEN) ? {{(32-HEN_W){1'b0}}, hen_r}
                                         : {{(32-CELLS_W){1'b0}}, cells_r};

  // effective modulus: zero acts as one, capped at the array size
  always_comb begin
    m_wide = {{(32-CELLS_W){1'b0}}, cells_r};
    if (m_wide == 32'd0) m_wide = 32'd1;
    else if (m_wide > 32'(NUM_CELLS)) m_wide = 32'(NUM_CELLS);
  end
  assign modulus = m_wide[MW-1:0];

  assign in_full   = front_busy || clearing;
  assign out_empty = !res_valid;

  bfh_front u_front (
    .clk, .rst_n,
    .in_push   (in_push && !in_full),
    .in_action,
    .in_key,
    .busy      (front_busy),
    .q_full,
    .q_push,
    .q_job     (wr_job)
  );

  bfh_queue u_queue (
    .clk, .rst_n,
    .push   (q_push),
    .wr_job,
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job
  );

  bfh_back #(.NUM_CELLS(NUM_CELLS)) u_back (
    .clk, .rst_n,
    .modulus,
    .hen         (hen_r),
    .q_empty,
    .q_job       (rd_job),
    .q_pop,
    .clearing,
    .res_valid,
    .res_all_set (out_all_set),
    .res_pop     (out_pop)
  );

endmodule
`default_nettype wire

>>> rtl/core/bfh_front.sv
// Front end: accepts items and computes the three 32-bit hashes.
// Depends on bfh_pkg.
`default_nettype none
module bfh_front
  import bfh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire logic             in_action,
  input  wire logic [KEY_W-1:0] in_key,
  output logic                  busy,
  input  wire logic             q_full,
  output logic                  q_push,
  output bfh_job_t              q_job
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t                 st_r;
  logic [SFH_STEP_W-1:0]   step_r;
  logic [15:0]             lo_r;
  logic [HASH_W-1:0]       h_r;
  logic [HASH_W-1:0]       h_nxt;
  bfh_job_t                job_r;

  assign busy   = (st_r != F_IDLE);
  assign q_push = (st_r == F_PUSH) && !q_full;
  assign q_job  = '{query: job_r.query, h0: job_r.h0, h1: job_r.h1, h2: h_r};

  // sfh: sixteen rounds then six finishing steps
  always_comb begin
    h_nxt = h_r;
    if (step_r < SFH_STEP_W'(SFH_ROUNDS)) begin
      h_nxt = sfh_round(h_r, lo_r);
    end else begin
      case (step_r - SFH_STEP_W'(SFH_ROUNDS))
        SFH_STEP_W'(0): h_nxt = h_r ^ (h_r << 3);
        SFH_STEP_W'(1): h_nxt = h_r + (h_r >> 5);
        SFH_STEP_W'(2): h_nxt = h_r ^ (h_r << 4);
        SFH_STEP_W'(3): h_nxt = h_r + (h_r >> 17);
        SFH_STEP_W'(4): h_nxt = h_r ^ (h_r << 25);
        SFH_STEP_W'(5): h_nxt = h_r + (h_r >> 6);
        default:        h_nxt = h_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      case (st_r)
        F_IDLE: if (in_push) st_r <= F_HASH;
        F_HASH: if (step_r == SFH_STEP_W'(SFH_STEPS - 1)) st_r <= F_PUSH;
        F_PUSH: if (!q_full) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_push) begin
      job_r.query <= in_action;
      job_r.h0    <= djb2_hash(in_key);
      job_r.h1    <= in_key[HASH_W-1:0];
      job_r.h2    <= '0;
      lo_r        <= in_key[15:0];
      h_r         <= SFH_INIT;
      step_r      <= '0;
    end else if (st_r == F_HASH) begin
      h_r    <= h_nxt;
      lo_r   <= lo_r + 16'd4;
      step_r <= step_r + SFH_STEP_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bfh_queue.sv
// Two-entry queue of hashed jobs between front and back.
// Depends on bfh_pkg.
`default_nettype none
module bfh_queue
  import bfh_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  bfh_job_t      wr_job,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output bfh_job_t      rd_job
);

  bfh_job_t    ent_r [2];
  logic        wp_r;
  logic        rp_r;
  logic [1:0]  cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign empty  = (cnt_r == 2'd0);
  assign rd_job = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) ent_r[wp_r] <= wr_job;
  end

endmodule
`default_nettype wire

>>> rtl/core/bfh_back.sv
// Back end: per enabled probe, a bit-serial modulo, then a read and optional set of
// the filter bit memory. Also clears the memory after reset. Depends on bfh_pkg.
`default_nettype none
module bfh_back
  import bfh_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF,
  localparam int IW = $clog2(NUM_CELLS),
  localparam int MW = $clog2(NUM_CELLS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [MW-1:0] modulus,
  input  wire logic [HEN_W-1:0] hen,
  input  wire logic          q_empty,
  input  bfh_job_t           q_job,
  output logic               q_pop,
  output logic               clearing,
  output logic               res_valid,
  output logic               res_all_set,
  input  wire logic          res_pop
);

  typedef enum logic [5:0] {
    B_CLEAR = 6'b000001,
    B_IDLE  = 6'b000010,
    B_SEL   = 6'b000100,
    B_DIV   = 6'b001000,
    B_RD    = 6'b010000,
    B_CHK   = 6'b100000
  } bstate_t;

  bstate_t           st_r;
  bfh_job_t          job_r;
  logic [1:0]        pi_r;
  logic [4:0]        dcnt_r;
  logic [HASH_W-1:0] dsh_r;
  logic [MW:0]       rem_r;
  logic [MW:0]       rem_sh;
  logic [IW-1:0]     clr_r;
  logic              all_r;
  logic              rv_r;
  logic              mem [NUM_CELLS];
  logic              rd_r;
  logic [IW-1:0]     idx;
  logic [HASH_W-1:0] hsel;
  logic              we;
  logic [IW-1:0]     wa;

  assign clearing    = (st_r == B_CLEAR);
  assign res_valid   = rv_r;
  assign res_all_set = all_r;
  assign q_pop       = (st_r == B_IDLE) && !q_empty && !rv_r;
  assign idx         = rem_r[IW-1:0];
  assign rem_sh      = {rem_r[MW-1:0], dsh_r[HASH_W-1]};

  always_comb begin
    case (pi_r)
      2'd0:    hsel = job_r.h0;
      2'd1:    hsel = job_r.h1;
      default: hsel = job_r.h2;
    endcase
  end

  // memory port: clear sweep or probe set
  assign we = clearing || (st_r == B_CHK && job_r.query != ACT_QUERY);
  assign wa = clearing ? clr_r : idx;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= !clearing;
    rd_r <= mem[idx];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= B_CLEAR;
      clr_r <= '0;
      rv_r  <= 1'b0;
    end else begin
      if (res_pop && rv_r) rv_r <= 1'b0;
      case (st_r)
        B_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(NUM_CELLS - 1)) st_r <= B_IDLE;
        end
        B_IDLE: if (q_pop) st_r <= B_SEL;
        B_SEL: begin
          if (pi_r == 2'd3) begin
            rv_r <= 1'b1;
            st_r <= B_IDLE;
          end else if (hen[pi_r]) begin
            st_r <= B_DIV;
          end
        end
        B_DIV: if (dcnt_r == 5'd31) st_r <= B_RD;
        B_RD:  st_r <= B_CHK;
        B_CHK: st_r <= B_SEL;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  // probe datapath
  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: begin
        if (q_pop) begin
          job_r <= q_job;
          pi_r  <= 2'd0;
          all_r <= 1'b1;
        end
      end
      B_SEL: begin
        if (pi_r != 2'd3) begin
          if (hen[pi_r]) begin
            dsh_r  <= hsel;
            rem_r  <= '0;
            dcnt_r <= '0;
          end else begin
            pi_r <= pi_r + 2'd1;
          end
        end
      end
      B_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_r  <= (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;
        dsh_r  <= dsh_r << 1;
        dcnt_r <= dcnt_r + 5'd1;
      end
      B_CHK: begin
        if (!rd_r) all_r <= 1'b0;
        pi_r <= pi_r + 2'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
